FILE: design/sdtl_pkg.sv
`timescale 1ns / 1ps
package sdtl_pkg;

   // fixed field widths
   localparam int DIR_W = 16;
   localparam int INDEX_W = 15;
   localparam int TEXEL_W = 24;
   localparam int WIDTH_W = 9;
   localparam int HEIGHT_W = 8;
   localparam int COLOR_W = 8;

   // angle and length datapath
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W = 34;
   localparam int SQ_W = 32;
   localparam int RAD_W = 48;
   localparam int ROOT_W = 24;
   localparam int NUM_W = 25;

   // register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKY_ENABLED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_HEIGHT = 2'd2;
   localparam logic [WIDTH_W-1:0] TEX_WIDTH_RESET = 9'd256;
   localparam logic [HEIGHT_W-1:0] TEX_HEIGHT_RESET = 8'd128;

   // item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // fields that ride along the whole pipeline
   typedef struct packed {
      logic op;
      logic [DIR_W-1:0] dir_y;
      logic [INDEX_W-1:0] texel_index;
      logic [TEXEL_W-1:0] texel_value;
   } meta_type;

   // arctangent of 2^-step as a 32-bit fraction of a turn
   function automatic logic [31:0] atan_turn(input logic [4:0] step);
      logic [31:0] angle;
      case (step)
         5'd0: angle = 32'h20000000;
         5'd1: angle = 32'h12E4051E;
         5'd2: angle = 32'h09FB385B;
         5'd3: angle = 32'h051111D4;
         5'd4: angle = 32'h028B0D43;
         5'd5: angle = 32'h0145D7E1;
         5'd6: angle = 32'h00A2F61E;
         5'd7: angle = 32'h00517C55;
         5'd8: angle = 32'h0028BE53;
         5'd9: angle = 32'h00145F2F;
         5'd10: angle = 32'h000A2F98;
         5'd11: angle = 32'h000517CC;
         5'd12: angle = 32'h00028BE6;
         5'd13: angle = 32'h000145F3;
         5'd14: angle = 32'h0000A2F9;
         5'd15: angle = 32'h0000517C;
         5'd16: angle = 32'h000028BE;
         5'd17: angle = 32'h0000145F;
         5'd18: angle = 32'h00000A2F;
         5'd19: angle = 32'h00000517;
         5'd20: angle = 32'h0000028B;
         5'd21: angle = 32'h00000145;
         5'd22: angle = 32'h000000A2;
         5'd23: angle = 32'h00000051;
         default: angle = 32'h00000000;
      endcase
      return angle;
   endfunction

endpackage

FILE: design/sdtl_cordic_sqrt.sv
`timescale 1ns / 1ps
module sdtl_cordic_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  sdtl_pkg::meta_type in_meta,
   input  logic signed [sdtl_pkg::DIR_W-1:0] in_x,
   input  logic signed [sdtl_pkg::DIR_W-1:0] in_z,
   input  logic [sdtl_pkg::SQ_W-1:0] in_sq,
   output logic out_valid,
   output sdtl_pkg::meta_type out_meta,
   output logic [31:0] out_angle,
   output logic [sdtl_pkg::ROOT_W-1:0] out_root
);

   localparam int STEPS = sdtl_pkg::CORDIC_STEPS;
   localparam int CW = sdtl_pkg::CORDIC_W;
   localparam int RW = sdtl_pkg::RAD_W;

   logic valid_ff [STEPS];
   sdtl_pkg::meta_type meta_ff [STEPS];
   logic [31:0] acc_ff [STEPS];
   logic [RW-1:0] root_ff [STEPS];
   logic signed [CW-1:0] a_ff [STEPS-1];
   logic signed [CW-1:0] b_ff [STEPS-1];
   logic [RW-1:0] rem_ff [STEPS-1];

   logic signed [CW-1:0] x_scaled;
   logic signed [CW-1:0] z_scaled;
   logic signed [CW-1:0] a_init;
   logic signed [CW-1:0] b_init;
   logic [31:0] acc_init;

   // fold the left half plane onto the right one
   always_comb begin
      x_scaled = CW'(in_x) <<< 14;
      z_scaled = CW'(in_z) <<< 14;
      if (z_scaled < 0) begin
         a_init = -z_scaled;
         b_init = -x_scaled;
         acc_init = 32'h8000_0000;
      end else begin
         a_init = z_scaled;
         b_init = x_scaled;
         acc_init = 32'h0000_0000;
      end
   end

   // one rotation and one square root digit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
      logic v_src;
      sdtl_pkg::meta_type m_src;
      logic signed [CW-1:0] a_src;
      logic signed [CW-1:0] b_src;
      logic [31:0] acc_src;
      logic [RW-1:0] rem_src;
      logic [RW-1:0] root_src;
      logic signed [CW-1:0] a_in;
      logic signed [CW-1:0] b_in;
      logic [31:0] acc_in;
      logic [RW-1:0] rem_in;
      logic [RW-1:0] root_in;
      logic [RW-1:0] trial;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign m_src = in_meta;
         assign a_src = a_init;
         assign b_src = b_init;
         assign acc_src = acc_init;
         assign rem_src = {in_sq, 16'b0};
         assign root_src = '0;
      end else begin : g_next
         assign v_src = valid_ff[k-1];
         assign m_src = meta_ff[k-1];
         assign a_src = a_ff[k-1];
         assign b_src = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      always_comb begin
         if (!b_src[CW-1]) begin
            a_in = a_src + (b_src >>> k);
            b_in = b_src - (a_src >>> k);
            acc_in = acc_src + sdtl_pkg::atan_turn(5'(k));
         end else begin
            a_in = a_src - (b_src >>> k);
            b_in = b_src + (a_src >>> k);
            acc_in = acc_src - sdtl_pkg::atan_turn(5'(k));
         end
         trial = root_src + BIT;
         if (rem_src >= trial) begin
            rem_in = rem_src - trial;
            root_in = (root_src >> 1) + BIT;
         end else begin
            rem_in = rem_src;
            root_in = root_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            meta_ff[k] <= m_src;
            acc_ff[k] <= acc_in;
            root_ff[k] <= root_in;
         end
      end

      // rotation vector and remainder are dead after the last stage
      if (k < STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               a_ff[k] <= a_in;
               b_ff[k] <= b_in;
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_meta = meta_ff[STEPS-1];
   assign out_angle = acc_ff[STEPS-1];
   assign out_root = root_ff[STEPS-1][sdtl_pkg::ROOT_W-1:0];

endmodule

FILE: design/sdtl_div.sv
`timescale 1ns / 1ps
module sdtl_div #(
   parameter int ANGLE_BITS = 16,
   parameter int SIDE_W = 82
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [SIDE_W-1:0] in_side,
   input  logic [sdtl_pkg::NUM_W-1:0] in_num,
   input  logic [sdtl_pkg::NUM_W-1:0] in_den,
   output logic out_valid,
   output logic [SIDE_W-1:0] out_side,
   output logic [ANGLE_BITS:0] out_quot
);

   localparam int Q_W = ANGLE_BITS + 1;
   localparam int NW = sdtl_pkg::NUM_W;
   localparam int REM_W = NW + ANGLE_BITS + 1;

   logic valid_ff [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic [Q_W-1:0] quot_ff [Q_W];
   logic [REM_W-1:0] rem_ff [Q_W-1];
   logic [NW-1:0] den_ff [Q_W-1];

   // restoring division, one quotient bit per stage, top bit first
   for (genvar j = 0; j < Q_W; j++) begin : g_step
      localparam int P = ANGLE_BITS - j;
      logic v_src;
      logic [SIDE_W-1:0] s_src;
      logic [REM_W-1:0] rem_src;
      logic [NW-1:0] den_src;
      logic [Q_W-1:0] quot_src;
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] rem_in;
      logic [Q_W-1:0] quot_in;

      if (j == 0) begin : g_first
         assign v_src = in_valid;
         assign s_src = in_side;
         assign rem_src = REM_W'(in_num) << ANGLE_BITS;
         assign den_src = in_den;
         assign quot_src = '0;
      end else begin : g_next
         assign v_src = valid_ff[j-1];
         assign s_src = side_ff[j-1];
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign quot_src = quot_ff[j-1];
      end

      always_comb begin
         shifted = REM_W'(den_src) << P;
         if (rem_src >= shifted) begin
            rem_in = rem_src - shifted;
            quot_in = quot_src | (Q_W'(1) << P);
         end else begin
            rem_in = rem_src;
            quot_in = quot_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[j] <= s_src;
            quot_ff[j] <= quot_in;
         end
      end

      if (j < Q_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_src;
            end
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_side = side_ff[Q_W-1];
   assign out_quot = quot_ff[Q_W-1];

endmodule

FILE: design/skybox_direction_texel_lookup_core.sv
`timescale 1ns / 1ps
// throughput: one item per cycle while the response is not stalled,
// set by the fully pipelined cordic, square root and divider
// a stalled response freezes the whole pipeline; writes and lookups share one store port
// reset: synchronous, clears all valid bits and the configuration registers (sky off, 256 x 128)
// the texel store is not cleared by reset; entries hold garbage until written
module skybox_direction_texel_lookup_core #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 128,
   parameter int ANGLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [sdtl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sdtl_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_op,
   input  logic signed [sdtl_pkg::DIR_W-1:0] req_dir_x,
   input  logic signed [sdtl_pkg::DIR_W-1:0] req_dir_y,
   input  logic signed [sdtl_pkg::DIR_W-1:0] req_dir_z,
   input  logic [sdtl_pkg::INDEX_W-1:0] req_texel_index,
   input  logic [sdtl_pkg::TEXEL_W-1:0] req_texel_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [sdtl_pkg::COLOR_W-1:0] rsp_red,
   output logic [sdtl_pkg::COLOR_W-1:0] rsp_green,
   output logic [sdtl_pkg::COLOR_W-1:0] rsp_blue,
   output logic rsp_hit
);

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SHIFT = 32 - ANGLE_BITS;
   localparam int META_W = $bits(sdtl_pkg::meta_type);
   localparam int SIDE_W = META_W + ANGLE_BITS + 1;
   localparam int WW = sdtl_pkg::WIDTH_W;
   localparam int HW = sdtl_pkg::HEIGHT_W;
   localparam int NW = sdtl_pkg::NUM_W;
   localparam int RTW = sdtl_pkg::ROOT_W;
   localparam int COL_PROD_W = WW + ANGLE_BITS;
   localparam int ROW_PROD_W = HW + ANGLE_BITS + 1;
   localparam int IDX_W = WW + WW + 1;

   // configuration registers
   logic sky_enabled_ff;
   logic [WW-1:0] tex_width_ff;
   logic [HW-1:0] tex_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sky_enabled_ff <= 1'b0;
         tex_width_ff <= sdtl_pkg::TEX_WIDTH_RESET;
         tex_height_ff <= sdtl_pkg::TEX_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sdtl_pkg::CSR_SKY_ENABLED: sky_enabled_ff <= csr_write_data[0];
            sdtl_pkg::CSR_TEX_WIDTH:   tex_width_ff <= csr_write_data;
            sdtl_pkg::CSR_TEX_HEIGHT:  tex_height_ff <= csr_write_data[HW-1:0];
            default: ;
         endcase
      end
   end

   // global pipeline enable, frozen while a response waits
   logic advance;
   logic o_valid_ff;

   assign advance = !o_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // squared length stage
   logic sq_valid_ff;
   sdtl_pkg::meta_type sq_meta_ff;
   logic signed [sdtl_pkg::DIR_W-1:0] sq_x_ff;
   logic signed [sdtl_pkg::DIR_W-1:0] sq_z_ff;
   logic [sdtl_pkg::SQ_W-1:0] sq_sum_ff;
   logic signed [31:0] x_sq;
   logic signed [31:0] y_sq;
   logic signed [31:0] z_sq;
   logic [sdtl_pkg::SQ_W-1:0] sq_sum_in;
   sdtl_pkg::meta_type sq_meta_in;

   always_comb begin
      x_sq = req_dir_x * req_dir_x;
      y_sq = req_dir_y * req_dir_y;
      z_sq = req_dir_z * req_dir_z;
      sq_sum_in = $unsigned(x_sq) + $unsigned(y_sq) + $unsigned(z_sq);
      sq_meta_in.op = req_op;
      sq_meta_in.dir_y = req_dir_y;
      sq_meta_in.texel_index = req_texel_index;
      sq_meta_in.texel_value = req_texel_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_meta_ff <= sq_meta_in;
         sq_x_ff <= req_dir_x;
         sq_z_ff <= req_dir_z;
         sq_sum_ff <= sq_sum_in;
      end
   end

   // angle about the vertical axis and vector length
   logic cordic_valid;
   sdtl_pkg::meta_type cordic_meta;
   logic [31:0] cordic_angle;
   logic [RTW-1:0] cordic_root;

   sdtl_cordic_sqrt u_cordic_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid_ff),
      .in_meta   (sq_meta_ff),
      .in_x      (sq_x_ff),
      .in_z      (sq_z_ff),
      .in_sq     (sq_sum_ff),
      .out_valid (cordic_valid),
      .out_meta  (cordic_meta),
      .out_angle (cordic_angle),
      .out_root  (cordic_root)
   );

   // round the angle and form the height ratio operands
   logic u_valid_ff;
   logic [SIDE_W-1:0] u_side_ff;
   logic [NW-1:0] u_num_ff;
   logic [NW-1:0] u_den_ff;
   logic [31:0] u_sum;
   logic [ANGLE_BITS-1:0] u_round;
   logic [ANGLE_BITS-1:0] omu;
   logic signed [NW:0] num_signed;
   logic [SIDE_W-1:0] u_side_in;

   always_comb begin
      u_sum = cordic_angle + 32'h8000_0000 + (32'd1 << (SHIFT - 1));
      u_round = u_sum[31:SHIFT];
      omu = ANGLE_BITS'(0) - u_round;
      num_signed = $signed({2'b00, cordic_root})
                 - ($signed((NW + 1)'($signed(cordic_meta.dir_y))) <<< 8);
      u_side_in = {cordic_meta, omu, (cordic_root != '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
      end else if (advance) begin
         u_valid_ff <= cordic_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u_side_ff <= u_side_in;
         u_num_ff <= num_signed[NW-1:0];
         u_den_ff <= {cordic_root, 1'b0};
      end
   end

   // height ratio scaled to the angle width
   logic div_valid;
   logic [SIDE_W-1:0] div_side;
   logic [ANGLE_BITS:0] div_quot;

   sdtl_div #(
      .ANGLE_BITS (ANGLE_BITS),
      .SIDE_W     (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (u_valid_ff),
      .in_side   (u_side_ff),
      .in_num    (u_num_ff),
      .in_den    (u_den_ff),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quot  (div_quot)
   );

   // scale to texel column and row
   logic m_valid_ff;
   sdtl_pkg::meta_type m_meta_ff;
   logic m_nz_ff;
   logic [WW-1:0] m_col_ff;
   logic [WW-1:0] m_row_ff;
   sdtl_pkg::meta_type div_meta;
   logic [ANGLE_BITS-1:0] div_omu;
   logic [COL_PROD_W-1:0] col_prod;
   logic [ROW_PROD_W-1:0] row_prod;

   always_comb begin
      div_meta = sdtl_pkg::meta_type'(div_side[SIDE_W-1 -: META_W]);
      div_omu = div_side[ANGLE_BITS:1];
      col_prod = COL_PROD_W'(tex_width_ff) * COL_PROD_W'(div_omu);
      row_prod = ROW_PROD_W'(tex_height_ff) * ROW_PROD_W'(div_quot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_meta_ff <= div_meta;
         m_nz_ff <= div_side[0];
         m_col_ff <= col_prod[COL_PROD_W-1:ANGLE_BITS];
         m_row_ff <= row_prod[ROW_PROD_W-1:ANGLE_BITS];
      end
   end

   // bounds check and store index
   logic i_valid_ff;
   sdtl_pkg::meta_type i_meta_ff;
   logic i_hit_ff;
   logic [IDX_W-1:0] i_idx_ff;
   logic i_hit_in;
   logic [IDX_W-1:0] i_idx_in;

   always_comb begin
      i_hit_in = (m_meta_ff.op == sdtl_pkg::OP_LOOKUP) && sky_enabled_ff && m_nz_ff
              && (m_col_ff < tex_width_ff) && (m_row_ff < WW'(tex_height_ff));
      i_idx_in = IDX_W'(m_row_ff) * IDX_W'(tex_width_ff) + IDX_W'(m_col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (advance) begin
         i_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         i_meta_ff <= m_meta_ff;
         i_hit_ff <= i_hit_in;
         i_idx_ff <= i_idx_in;
      end
   end

   // texel store: one port, write or read per transfer
   logic [sdtl_pkg::TEXEL_W-1:0] store_mem [STORE_DEPTH];
   logic [sdtl_pkg::TEXEL_W-1:0] rd_ff;
   logic o_hit_ff;
   logic o_op_ff;
   logic [31:0] lookup_idx;
   logic [31:0] write_idx;
   logic [ADDR_W-1:0] mem_addr;
   logic is_lookup;
   logic do_write;

   always_comb begin
      lookup_idx = 32'(i_idx_ff);
      write_idx = 32'(i_meta_ff.texel_index);
      is_lookup = (i_meta_ff.op == sdtl_pkg::OP_LOOKUP);
      mem_addr = is_lookup ? lookup_idx[ADDR_W-1:0] : write_idx[ADDR_W-1:0];
      do_write = i_valid_ff && !is_lookup && (write_idx < 32'(STORE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (do_write) begin
            store_mem[mem_addr] <= i_meta_ff.texel_value;
         end
         rd_ff <= store_mem[mem_addr];
         o_hit_ff <= i_hit_ff && (lookup_idx < 32'(STORE_DEPTH));
         o_op_ff <= i_meta_ff.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         o_valid_ff <= i_valid_ff;
      end
   end

   // response, black on a miss
   assign rsp_valid = o_valid_ff;
   assign rsp_hit = o_hit_ff;
   assign rsp_red = o_hit_ff ? rd_ff[23:16] : '0;
   assign rsp_green = o_hit_ff ? rd_ff[15:8] : '0;
   assign rsp_blue = o_hit_ff ? rd_ff[7:0] : '0;

   // a hit only comes from a lookup with the sky enabled
   a_hit_is_lookup: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (o_op_ff == sdtl_pkg::OP_LOOKUP && sky_enabled_ff))
      else $error("hit on a write or with sky disabled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !i_valid_ff && !sq_valid_ff))
      else $error("valid survived reset");

   // an item in the last stage moves on only when the response is taken
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(o_hit_ff) && $stable(rd_ff)))
      else $error("response lost under stall");

endmodule

FILE: tb/tb_skybox_direction_texel_lookup_core.sv
`timescale 1ns / 1ps
module tb_skybox_direction_texel_lookup_core;

   localparam int TEXELS = 32768;
   localparam int DRAIN_CYCLES = 60;
   localparam int HANG_LIMIT = 4000;

   typedef logic [sdtl_pkg::DIR_W-1:0] dir_type;
   typedef logic [sdtl_pkg::INDEX_W-1:0] index_type;
   typedef logic [sdtl_pkg::TEXEL_W-1:0] texel_type;
   typedef logic [sdtl_pkg::CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      logic [sdtl_pkg::COLOR_W-1:0] red;
      logic [sdtl_pkg::COLOR_W-1:0] green;
      logic [sdtl_pkg::COLOR_W-1:0] blue;
      logic hit;
   } color_type;

   typedef struct packed {
      logic sky;
      logic op;
      dir_type x;
      dir_type y;
      dir_type z;
      index_type index;
      texel_type value;
      logic fixed;
      color_type color;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [sdtl_pkg::CSR_INDEX_W-1:0] csr_index = sdtl_pkg::CSR_SKY_ENABLED;
   logic [sdtl_pkg::CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = sdtl_pkg::OP_WRITE;
   logic signed [sdtl_pkg::DIR_W-1:0] req_dir_x = '0;
   logic signed [sdtl_pkg::DIR_W-1:0] req_dir_y = '0;
   logic signed [sdtl_pkg::DIR_W-1:0] req_dir_z = '0;
   logic [sdtl_pkg::INDEX_W-1:0] req_texel_index = '0;
   logic [sdtl_pkg::TEXEL_W-1:0] req_texel_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [sdtl_pkg::COLOR_W-1:0] rsp_red;
   logic [sdtl_pkg::COLOR_W-1:0] rsp_green;
   logic [sdtl_pkg::COLOR_W-1:0] rsp_blue;
   logic rsp_hit;

   skybox_direction_texel_lookup_core dut (.*);

   always #4 clock = ~clock;

   // shadow of the texture store and registers
   texel_type shadow_texels [TEXELS];
   bit texel_loaded [TEXELS];
   logic shadow_sky = 1'b0;
   int unsigned shadow_width = sdtl_pkg::TEX_WIDTH_RESET;
   int unsigned shadow_height = sdtl_pkg::TEX_HEIGHT_RESET;

   color_type pending_colors [$];
   bit fixed_flags [$];
   color_type fixed_colors [$];
   int mismatches = 0;
   int lookups_sent = 0;
   int hits_seen = 0;
   int responses_seen = 0;
   bit quiet = 1'b0;
   int hang_count = 0;

   logic [31:0] atan_steps [sdtl_pkg::CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   // heading of (cos, sin) in 2^-32 turns by vectoring rotations
   function automatic logic [31:0] heading_turn(longint sinv, longint cosv);
      longint a, b, na, nb;
      logic [31:0] acc;
      a = cosv * 16384;
      b = sinv * 16384;
      acc = '0;
      if (a < 0) begin
         a = -a;
         b = -b;
         acc = 32'h80000000;
      end
      for (int i = 0; i < sdtl_pkg::CORDIC_STEPS; i++) begin
         if (b >= 0) begin
            na = a + (b >>> i);
            nb = b - (a >>> i);
            acc = acc + atan_steps[i];
         end else begin
            na = a - (b >>> i);
            nb = b + (a >>> i);
            acc = acc - atan_steps[i];
         end
         a = na;
         b = nb;
      end
      return acc;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // store index a lookup reads, or -1 on a miss
   function automatic int sky_texel_index(dir_type dx, dir_type dy, dir_type dz);
      longint x, y, z, len, num, t, row, col, idx;
      logic [32:0] rounded;
      logic [15:0] u, omu;
      x = longint'($signed(dx));
      y = longint'($signed(dy));
      z = longint'($signed(dz));
      if (!shadow_sky || (x * x + y * y + z * z) == 0) return -1;
      rounded = {1'b0, heading_turn(x, z) + 32'h80000000} + 33'h8000;
      u = rounded[31:16];
      omu = 16'(17'h10000 - u);
      col = (longint'(shadow_width) * omu) >> 16;
      len = longint'(int_sqrt(longint'((x * x + y * y + z * z)) << 16));
      num = len - y * 256;
      t = (num << 16) / (2 * len);
      row = (longint'(shadow_height) * t) >> 16;
      if (col >= shadow_width || row >= shadow_height) return -1;
      idx = row * shadow_width + col;
      if (idx >= TEXELS) return -1;
      return int'(idx);
   endfunction

   // one item transfer; the expected color is queued at acceptance
   task automatic send_item(logic op, dir_type x, dir_type y, dir_type z, index_type index,
                            texel_type value, bit fixed, color_type fixed_color);
      bit taken;
      color_type predicted;
      int idx;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      req_texel_index <= index;
      req_texel_value <= value;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predicted = '0;
      if (op == sdtl_pkg::OP_WRITE) begin
         shadow_texels[index] = value;
         texel_loaded[index] = 1'b1;
      end else begin
         lookups_sent++;
         idx = sky_texel_index(x, y, z);
         if (idx >= 0) predicted = {shadow_texels[idx], 1'b1};
      end
      pending_colors.push_back(predicted);
      fixed_flags.push_back(fixed);
      fixed_colors.push_back(fixed_color);
   endtask

   // lookup, loading the texel it will read first if still unwritten
   task automatic send_lookup(dir_type x, dir_type y, dir_type z);
      int idx;
      idx = sky_texel_index(x, y, z);
      if (idx >= 0 && !texel_loaded[idx])
         send_item(sdtl_pkg::OP_WRITE, dir_type'($urandom), dir_type'($urandom),
                   dir_type'($urandom), index_type'(idx), texel_type'($urandom), 1'b0, '0);
      send_item(sdtl_pkg::OP_LOOKUP, x, y, z, index_type'($urandom), texel_type'($urandom),
                1'b0, '0);
   endtask

   task automatic csr_write(logic [sdtl_pkg::CSR_INDEX_W-1:0] index, csr_data_type data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // reprogram only once the pipeline has drained
   task automatic set_sky(logic sky, int unsigned width, int unsigned height);
      req_valid <= 1'b0;
      wait (pending_colors.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(sdtl_pkg::CSR_SKY_ENABLED, csr_data_type'(sky));
      csr_write(sdtl_pkg::CSR_TEX_WIDTH, csr_data_type'(width));
      csr_write(sdtl_pkg::CSR_TEX_HEIGHT, csr_data_type'(height));
      shadow_sky = sky;
      shadow_width = width & 9'h1FF;
      shadow_height = height & 8'hFF;
   endtask

   // random response stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      logic stall_next;
      stall_next = 1'b0;
      if (stall_left > 0) begin
         stall_left--;
         stall_next = 1'b1;
      end else if (!reset && !quiet && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 8);
         stall_next = 1'b1;
      end
      rsp_stall <= stall_next;
   end

   // response check and hang watchdog
   always @(negedge clock) begin
      color_type got, want;
      bit fixed;
      color_type typed;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_red, rsp_green, rsp_blue, rsp_hit};
         responses_seen++;
         if (got.hit) hits_seen++;
         if (pending_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_colors.pop_front();
            fixed = fixed_flags.pop_front();
            typed = fixed_colors.pop_front();
            if (fixed) want = typed;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response mismatch: expected r=%h g=%h b=%h hit=%b, ",
                            "got r=%h g=%h b=%h hit=%b"},
                           want.red, want.green, want.blue, want.hit,
                           got.red, got.green, got.blue, got.hit);
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         hang_count = 0;
      else
         hang_count++;
      if (hang_count >= HANG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // directed rows: sky off first with typed results, then sky on with typed and predicted rows
   stim_row_type directed [19] = '{
      '{1'b0, sdtl_pkg::OP_WRITE, 16'h0, 16'h0, 16'h0, 15'h0, 24'hFFFFFF, 1'b1, '0},
      '{1'b0, sdtl_pkg::OP_WRITE, 16'h0, 16'h0, 16'h0, 15'h7FFF, 24'h000000, 1'b1, '0},
      '{1'b0, sdtl_pkg::OP_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0080, 24'hA5C33C, 1'b1,
        '0},
      '{1'b0, sdtl_pkg::OP_LOOKUP, 16'h7FFF, 16'h0, 16'h0, 15'h0, 24'h0, 1'b1, '0},
      '{1'b0, sdtl_pkg::OP_LOOKUP, 16'h8000, 16'h8000, 16'h8000, 15'h0, 24'h0, 1'b1, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0, 16'h0, 16'h0, 15'h0, 24'h0, 1'b1, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0, 16'h8000, 16'h0, 15'h0, 24'h0, 1'b1, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0, 16'h7FFF, 16'h0, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0, 16'h0001, 16'h0, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h7FFF, 16'h0, 16'h0, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h8000, 16'h0, 16'h0, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0, 16'h0, 16'h7FFF, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0, 16'h0, 16'h8000, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0, 16'h0, 16'hFFFF, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h8000, 16'h8000, 16'h8000, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h8000, 16'h0, 16'hFFFF, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_LOOKUP, 16'h0001, 16'hFFFF, 16'h8000, 15'h0, 24'h0, 1'b0, '0},
      '{1'b1, sdtl_pkg::OP_WRITE, 16'h0, 16'h0, 16'h0, 15'h7FFF, 24'h123456, 1'b1, '0}
   };

   initial begin
      int unsigned widths [8] = '{256, 1, 256, 37, 0, 511, 200, 256};
      int unsigned heights [8] = '{128, 1, 1, 128, 64, 255, 0, 100};
      dir_type x, y, z;
      int unsigned span;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed[k]) begin
         if (directed[k].sky != shadow_sky) set_sky(directed[k].sky, 256, 128);
         if (directed[k].op == sdtl_pkg::OP_LOOKUP && !directed[k].fixed)
            send_lookup(directed[k].x, directed[k].y, directed[k].z);
         else
            send_item(directed[k].op, directed[k].x, directed[k].y, directed[k].z,
                      directed[k].index, directed[k].value, directed[k].fixed,
                      directed[k].color);
      end

      // random phases over several texture shapes, sky toggled
      for (int p = 0; p < 9; p++) begin
         if (p == 8) begin
            set_sky(1'b1, 256, 128);
            quiet = 1'b1;
         end else if (p == 6) begin
            set_sky(1'b0, widths[p], heights[p]);
         end else begin
            set_sky(1'b1, widths[p], heights[p]);
         end
         span = shadow_width * shadow_height;
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               if (span != 0 && span <= TEXELS && $urandom_range(0, 2) != 0)
                  send_item(sdtl_pkg::OP_WRITE, dir_type'($urandom), dir_type'($urandom),
                            dir_type'($urandom), index_type'($urandom_range(0, span - 1)),
                            texel_type'($urandom), 1'b0, '0);
               else
                  send_item(sdtl_pkg::OP_WRITE, dir_type'($urandom), dir_type'($urandom),
                            dir_type'($urandom), index_type'($urandom),
                            texel_type'($urandom), 1'b0, '0);
            end else begin
               x = dir_type'($urandom);
               y = dir_type'($urandom);
               z = dir_type'($urandom);
               case ($urandom_range(0, 4))
                  0: begin
                     x = $signed(x) >>> $urandom_range(4, 15);
                     y = $signed(y) >>> $urandom_range(4, 15);
                     z = $signed(z) >>> $urandom_range(4, 15);
                  end
                  1: case ($urandom_range(0, 2))
                        0: x = '0;
                        1: y = '0;
                        default: z = '0;
                     endcase
                  default: ;
               endcase
               send_lookup(x, y, z);
            end
         end
      end

      req_valid <= 1'b0;
      wait (pending_colors.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d responses, %0d lookups with %0d texel hits", responses_seen,
               lookups_sent, hits_seen);
      $display("shapes from 0x0 to 511x255, sky on and off, %0d mismatches", mismatches);
      if (mismatches == 0 && pending_colors.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
